@@ rtl/sgrm_pkg.sv @@
`default_nettype none

package sgrm_pkg;

  // Fixed field widths of the block's ports.
  localparam int unsigned IndexWidth  = 32;
  localparam int unsigned LenWidth    = 13;
  localparam int unsigned ResultWidth = 32;

  // Command codes carried by each input transfer.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TERM = 1'b1
  } command_e;

endpackage

`default_nettype wire

@@ rtl/sparse_gather_row_mac_top.sv @@
`default_nettype none

// Sparse row gather and multiply-accumulate. The host fills the vector store with load
// transfers (command 0, element_index as address, sample_value as data); loads outside the
// store are dropped and never produce a result. It then streams weight terms (command 1):
// a term whose index is non-negative, below vector_length and inside the store adds
// weight * vector[index] into a wrapping ACC_WIDTH-bit accumulator. On a term with
// last_term set, the accumulator is multiplied by row_gain, shifted right arithmetically
// by 2*FRAC_BITS, saturated to 32 bits (saturated_o flags clipping), sent as one output
// transfer and cleared. An empty row is sent as one out-of-range last term. All values are
// Q.FRAC_BITS fixed point, so a row gain of 1.0 is 2**FRAC_BITS. Items are handled one at
// a time: a load only writes the vector store, a term that is not last passes through the
// vector memory read, the weight multiply and the accumulate, and a last term adds the
// two-part scale multiply, the partial product sum and the shift and saturate step, then
// waits while the output register stays occupied. A new item is taken while an earlier
// result waits in the output register. The vector store holds no reset; the user must
// load entries before they are read, as the block itself does not enforce this.
module sparse_gather_row_mac_top #(
  parameter int unsigned VECTOR_DEPTH = 4096,
  parameter int unsigned VALUE_WIDTH  = 16,
  parameter int unsigned FRAC_BITS    = 12,
  parameter int unsigned ACC_WIDTH    = 48
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [sgrm_pkg::LenWidth-1:0]   cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   command_i,
  input  wire logic signed [sgrm_pkg::IndexWidth-1:0] element_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0]          sample_value_i,
  input  wire logic signed [VALUE_WIDTH-1:0]          row_gain_i,
  input  wire logic                                   last_term_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [sgrm_pkg::ResultWidth-1:0]     row_result_o,
  output logic                                        saturated_o
);

  localparam int unsigned AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int unsigned PRW   = 2 * VALUE_WIDTH;            // weight * element
  localparam int unsigned LoW   = ACC_WIDTH / 2;              // low accumulator slice
  localparam int unsigned HiW   = ACC_WIDTH - LoW;            // high accumulator slice
  localparam int unsigned PloW  = VALUE_WIDTH + LoW + 1;      // scale * low slice
  localparam int unsigned PhiW  = VALUE_WIDTH + HiW;          // scale * high slice
  localparam int unsigned FW    = ACC_WIDTH + VALUE_WIDTH;    // full scaled product
  localparam int unsigned RW    = sgrm_pkg::ResultWidth;
  localparam int unsigned EW    = FW + RW;                    // headroom for the shift
  localparam int unsigned Shift = 2 * FRAC_BITS;
  localparam int unsigned IW    = sgrm_pkg::IndexWidth;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MAC  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SUM  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [sgrm_pkg::LenWidth-1:0] vlen_q;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= '0;
    end else if (cfg_we_i) begin
      vlen_q <= cfg_wdata_i;
    end
  end

  // Input decode. A non-negative index is compared against the store depth and,
  // for terms, against the configured vector length.
  logic in_xfer;
  logic idx_nonneg;
  logic in_store;
  logic in_vlen;
  logic is_load;
  logic is_term;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign idx_nonneg = !element_index_i[IW-1];
  assign in_store   = idx_nonneg && (element_index_i < IW'(VECTOR_DEPTH));
  assign in_vlen    = element_index_i < {{(IW - sgrm_pkg::LenWidth){1'b0}}, vlen_q};
  assign is_load    = (sgrm_pkg::command_e'(command_i) == sgrm_pkg::CMD_LOAD);
  assign is_term    = !is_load;

  logic [VALUE_WIDTH-1:0] rdata;

  sgrm_vec_ram #(
    .DEPTH (VECTOR_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && is_load && in_store),
    .waddr_i (element_index_i[AW-1:0]),
    .wdata_i (sample_value_i),
    .re_i    (in_xfer && is_term),
    .raddr_i (element_index_i[AW-1:0]),
    .rdata_o (rdata)
  );

  // Term registers, captured when a term is accepted.
  logic signed [VALUE_WIDTH-1:0] weight_q;
  logic signed [VALUE_WIDTH-1:0] scale_q;
  logic                          last_q;
  logic                          hit_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_term) begin
      weight_q <= sample_value_i;
      scale_q  <= row_gain_i;
      last_q   <= last_term_i;
      hit_q    <= in_store && in_vlen;
    end
  end

  // Weight times gathered element, registered before the accumulate.
  logic signed [PRW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      prod_q <= weight_q * $signed(rdata);
    end
  end

  // The accumulator wraps at ACC_WIDTH bits.
  logic [ACC_WIDTH-1:0]     acc_q, acc_d;
  logic [ACC_WIDTH+PRW-1:0] prod_ext;

  assign prod_ext = {{ACC_WIDTH{prod_q[PRW-1]}}, prod_q};

  // Row scale multiply, split into a low unsigned slice and a high signed slice.
  logic signed [LoW:0]      acc_lo;
  logic signed [HiW-1:0]    acc_hi;
  logic signed [PloW-1:0]   plo_q;
  logic signed [PhiW-1:0]   phi_q;

  assign acc_lo = {1'b0, acc_q[LoW-1:0]};
  assign acc_hi = acc_q[ACC_WIDTH-1:LoW];

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      plo_q <= scale_q * acc_lo;
      phi_q <= scale_q * acc_hi;
    end
  end

  logic [FW-1:0] full_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      full_q <= {phi_q, {LoW{1'b0}}} + {{(FW - PloW){plo_q[PloW-1]}}, plo_q};
    end
  end

  // Arithmetic shift back to Q.FRAC_BITS, then clip to the result width.
  logic signed [EW-1:0] full_ext;
  logic signed [EW-1:0] shifted;
  logic                 fits;
  logic [RW-1:0]        result;
  logic                 sat;

  assign full_ext = {{RW{full_q[FW-1]}}, full_q};
  assign shifted  = full_ext >>> Shift;
  assign fits     = (&shifted[EW-1:RW-1]) || !(|shifted[EW-1:RW-1]);
  assign sat      = !fits;

  always_comb begin
    if (fits) begin
      result = shifted[RW-1:0];
    end else if (shifted[EW-1]) begin
      result = {1'b1, {(RW - 1){1'b0}}};
    end else begin
      result = {1'b0, {(RW - 1){1'b1}}};
    end
  end

  // The output register frees up in the same cycle its transfer completes.
  logic slot_free;
  logic emit;

  assign slot_free = !out_valid_o || out_ready_i;
  assign emit      = (state_q == S_OUT) && slot_free;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && is_term) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_MAC;
      end
      S_MAC: begin
        if (hit_q) begin
          acc_d = acc_q + prod_ext[ACC_WIDTH-1:0];
        end
        state_d = last_q ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          acc_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_result_o <= result;
      saturated_o  <= sat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sgrm_vec_ram.sv @@
`default_nettype none

module sgrm_vec_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 12
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
